[rtl/core/pct_pkg.sv]
package pct_pkg;

    // Input beat: send request or acknowledgement
    typedef struct packed {
        logic        action;
        logic [7:0]  command_code;
        logic [7:0]  ack_sequence;
        logic [31:0] now_time;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot_index;
        logic [7:0] sent_sequence;
    } out_t;

    // Result status codes
    localparam logic [2:0] ST_SENT       = 3'd0;
    localparam logic [2:0] ST_SUPPRESSED = 3'd1;
    localparam logic [2:0] ST_CLEARED    = 3'd2;
    localparam logic [2:0] ST_NO_SLOT    = 3'd3;
    localparam logic [2:0] ST_ACK_MATCH  = 3'd4;
    localparam logic [2:0] ST_ACK_MISS   = 3'd5;

    // Action codes
    localparam logic ACT_SEND = 1'b0;
    localparam logic ACT_ACK  = 1'b1;

    // Sequence numbers run 0x80..0xFF and wrap
    localparam logic [7:0] SEQ_FIRST = 8'h80;
    localparam logic [7:0] SEQ_WRAP  = 8'hFF;

    // Register reset values
    localparam logic [31:0] RETRY_TIMEOUT_RST = 32'd60;
    localparam logic [31:0] UPGRADE_HOLD_RST  = 32'd21600;
    localparam logic [31:0] OTHER_HOLD_RST    = 32'd300;
    localparam logic [6:0]  UPGRADE_CODE_RST  = 7'd85;

    // Register indexes
    typedef enum logic [1:0] {
        CFG_RETRY_TIMEOUT = 2'd0,
        CFG_UPGRADE_HOLD  = 2'd1,
        CFG_OTHER_HOLD    = 2'd2,
        CFG_UPGRADE_CODE  = 2'd3
    } cfg_idx_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic advance;
        logic commit;
    } pct_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
    } pct_stat_t;

endpackage

[rtl/core/pct_ctrl.sv]
module pct_ctrl
    import pct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  pct_stat_t stat,
    output pct_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        resolved;
    logic        out_free;

    assign resolved  = stat.hit || stat.last;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.start   = 1'b0;
        cmd.advance = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Advance until resolved, then hold until the output slot frees
                cmd.advance = !resolved;
                if (resolved && out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    a_no_advance_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.advance && cmd.commit))
        else $error("advance and commit at once");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!$past(out_valid_reg) || out_ready || !out_valid_reg))
        else $error("commit would overwrite a waiting result");

    a_commit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result lost after commit");

endmodule

[rtl/core/pct_dp.sv]
module pct_dp
    import pct_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pct_cmd_t    cmd,
    output pct_stat_t   stat,
    input  in_t         in_data,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    // Entry payload: command, sequence, time
    typedef struct packed {
        logic [6:0]  command;
        logic [7:0]  sequence_no;
        logic [31:0] stamp;
    } entry_t;

    entry_t mem [QUEUE_DEPTH];

    // Configuration
    logic [31:0] retry_timeout_reg;
    logic [31:0] upgrade_hold_reg;
    logic [31:0] other_hold_reg;
    logic [6:0]  upgrade_code_reg;

    // Table flags and sequence counter
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] conf_reg;
    logic [7:0]             seq_reg;
    logic [7:0]             seq_next;

    // Scan pipeline
    in_t              item_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [IDX_W-1:0] rd_idx;
    logic             pipe_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    entry_t           rd_entry_reg;
    logic             rd_valid_reg;
    logic             rd_conf_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    out_t             out_reg;

    // Evaluation
    logic [6:0]       send_cmd;
    logic             is_ack;
    logic             cmd_zero;
    logic [31:0]      age;
    logic [31:0]      hold;
    logic             match_send;
    logic             match_ack;
    logic             expired;
    logic             clear_hit;
    logic             supp_hit;
    logic             free_here;
    logic             alloc_ok;
    logic [IDX_W-1:0] alloc_idx;
    logic             alloc_we;
    logic             confirm_we;
    logic             clear_we;
    out_t             res;
    logic [IDX_W+2:0] chk_ext;
    logic [IDX_W+2:0] alloc_ext;

    assign rd_idx   = rd_cnt_reg[IDX_W-1:0];
    assign send_cmd = item_reg.command_code[6:0];
    assign is_ack   = (item_reg.action == ACT_ACK);
    assign cmd_zero = !is_ack && (send_cmd == 7'd0);
    assign age      = item_reg.now_time - rd_entry_reg.stamp;
    assign hold     = (send_cmd == upgrade_code_reg) ? upgrade_hold_reg : other_hold_reg;

    // Compare the entry under check
    assign match_send = pipe_vld_reg && rd_valid_reg && (rd_entry_reg.command == send_cmd);
    assign match_ack  = pipe_vld_reg && rd_valid_reg
                        && (rd_entry_reg.sequence_no == item_reg.ack_sequence)
                        && (item_reg.command_code == {1'b1, rd_entry_reg.command});
    assign expired    = age > hold;
    assign clear_hit  = match_send && rd_conf_reg && expired;
    assign supp_hit   = match_send && (rd_conf_reg ? !expired : (age < retry_timeout_reg));

    // First free slot seen so far, including this one
    assign free_here = pipe_vld_reg && !rd_valid_reg;
    assign alloc_ok  = free_found_reg || free_here;
    assign alloc_idx = free_found_reg ? free_idx_reg : chk_idx_reg;

    assign stat.hit  = cmd_zero || (is_ack ? match_ack : (clear_hit || supp_hit));
    assign stat.last = pipe_vld_reg && (chk_idx_reg == LAST_IDX);

    assign confirm_we = cmd.commit && is_ack && match_ack;
    assign clear_we   = cmd.commit && !is_ack && !cmd_zero && clear_hit;
    assign alloc_we   = cmd.commit && !is_ack && !cmd_zero && !clear_hit && !supp_hit
                        && alloc_ok;

    assign chk_ext   = {3'b000, chk_idx_reg};
    assign alloc_ext = {3'b000, alloc_idx};
    assign seq_next  = (seq_reg == SEQ_WRAP) ? SEQ_FIRST : seq_reg + 8'd1;

    // Resolve the result beat
    always_comb
    begin
        res.status        = ST_NO_SLOT;
        res.slot_index    = 3'd0;
        res.sent_sequence = 8'd0;
        priority if (cmd_zero)
        begin
            res.status = ST_SUPPRESSED;
        end
        else if (is_ack)
        begin
            if (match_ack)
            begin
                res.status     = ST_ACK_MATCH;
                res.slot_index = chk_ext[2:0];
            end
            else
            begin
                res.status = ST_ACK_MISS;
            end
        end
        else if (clear_hit)
        begin
            res.status     = ST_CLEARED;
            res.slot_index = chk_ext[2:0];
        end
        else if (supp_hit)
        begin
            res.status = ST_SUPPRESSED;
        end
        else if (alloc_ok)
        begin
            res.status        = ST_SENT;
            res.slot_index    = alloc_ext[2:0];
            res.sent_sequence = seq_reg;
        end
        else
        begin
            res.status = ST_NO_SLOT;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_timeout_reg <= RETRY_TIMEOUT_RST;
            upgrade_hold_reg  <= UPGRADE_HOLD_RST;
            other_hold_reg    <= OTHER_HOLD_RST;
            upgrade_code_reg  <= UPGRADE_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RETRY_TIMEOUT: retry_timeout_reg <= cfg_data;
                CFG_UPGRADE_HOLD:  upgrade_hold_reg  <= cfg_data;
                CFG_OTHER_HOLD:    other_hold_reg    <= cfg_data;
                CFG_UPGRADE_CODE:  upgrade_code_reg  <= cfg_data[6:0];
                default:           retry_timeout_reg <= retry_timeout_reg;
            endcase
        end
    end

    // Entry flags and sequence counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            conf_reg  <= '0;
            seq_reg   <= SEQ_FIRST;
        end
        else
        begin
            if (confirm_we)
            begin
                conf_reg[chk_idx_reg] <= 1'b1;
            end
            if (clear_we)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
                conf_reg[chk_idx_reg]  <= 1'b0;
            end
            if (alloc_we)
            begin
                valid_reg[alloc_idx] <= 1'b1;
                conf_reg[alloc_idx]  <= 1'b0;
                seq_reg              <= seq_next;
            end
        end
    end

    // Entry memory: write on allocation, registered read during scan
    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            mem[alloc_idx] <= '{command: send_cmd, sequence_no: seq_reg,
                                stamp: item_reg.now_time};
        end
        if (cmd.advance && (rd_cnt_reg != DEPTH_CNT))
        begin
            rd_entry_reg <= mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
            rd_conf_reg  <= conf_reg[rd_idx];
            chk_idx_reg  <= rd_idx;
        end
        if (cmd.advance && free_here && !free_found_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (cmd.start)
        begin
            item_reg <= in_data;
        end
        if (cmd.commit)
        begin
            out_reg <= res;
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            rd_cnt_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.advance)
        begin
            if (rd_cnt_reg != DEPTH_CNT)
            begin
                rd_cnt_reg   <= rd_cnt_reg + CNT_W'(1);
                pipe_vld_reg <= 1'b1;
            end
            else
            begin
                pipe_vld_reg <= 1'b0;
            end
            if (free_here)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    assign out_data = out_reg;

    a_seq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg[7])
        else $error("sequence counter left the 0x80..0xFF range");

    a_commit_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (stat.hit || stat.last))
        else $error("commit before the scan resolved");

    a_alloc_grows_table: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_we |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("allocation did not take a free slot");

endmodule

[rtl/core/pending_command_tracker_unit.sv]
// Pending command tracker.
// Input channel (in_valid/in_ready/in_data): one beat is a send request or a
// received acknowledgement with its time stamp. Output channel
// (out_valid/out_ready/out_data): exactly one result beat per input beat,
// in order. Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
// writes the retry timeout, both hold times and the upgrade code; it is
// always ready and should be used while no item is in flight.
// Timing: a beat is accepted in the idle state; the table is then scanned
// one entry per cycle through a registered memory read until the request
// resolves (a send of code zero resolves at once, a match stops the scan
// early, otherwise all entries are visited); its result is loaded into the
// output register once that register is free, and out_valid rises at that
// same edge. No new beat is accepted until that result has been loaded.
// The next beat is accepted while a result waits in the output register;
// if the receiver stalls, the following item completes its scan and holds
// until that register frees.
// Reset: the table is emptied, the sequence counter returns to 0x80 and the
// registers take their reset values; no clearing pass is needed.
module pending_command_tracker_unit
    import pct_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pct_cmd_t  cmd;
    pct_stat_t stat;
    logic      cfg_we;

    // Configuration is taken every cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pct_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

[test/pending_command_tracker_unit_test.sv]
`timescale 1ns / 100ps

module pending_command_tracker_unit_test;
    import pct_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WRAP_CAP    = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_RETRY_TIMEOUT;
    logic [31:0] cfg_data  = '0;

    // Shadow copy of the command table and its settings
    logic [7:0]  slot_cmd   [QUEUE_DEPTH];
    logic [7:0]  slot_seq   [QUEUE_DEPTH];
    logic [31:0] slot_time  [QUEUE_DEPTH];
    logic        slot_acked [QUEUE_DEPTH];
    logic [7:0]  seq_counter;
    bit          seq_wrapped;
    logic [31:0] retry_timeout;
    logic [31:0] upgrade_hold;
    logic [31:0] other_hold;
    logic [6:0]  upgrade_cmd;

    // Directed stimulus rows; typed rows carry their own expected result
    typedef struct {
        in_t  req;
        bit   typed;
        out_t want;
    } dir_row_t;

    dir_row_t    dir_rows[$];
    out_t        pending_results[$];
    out_t        expected_res;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [31:0] clock_now;

    pending_command_tracker_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Work out the result of one request beat and update the shadow table
    function automatic out_t track_request(input in_t req);
        out_t        res;
        logic [7:0]  cmd;
        logic [31:0] age;
        logic [31:0] hold;
        int          i;
        res = '0;
        if (req.action == ACT_ACK)
        begin
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (slot_cmd[i] != 8'h00 && slot_seq[i] == req.ack_sequence &&
                    req.command_code == (slot_cmd[i] | 8'h80))
                begin
                    slot_acked[i]   = 1'b1;
                    res.status      = ST_ACK_MATCH;
                    res.slot_index  = i[2:0];
                    return res;
                end
            end
            res.status = ST_ACK_MISS;
            return res;
        end
        cmd = {1'b0, req.command_code[6:0]};
        if (cmd == 8'h00)
        begin
            res.status = ST_SUPPRESSED;
            return res;
        end
        // Scan entries holding the same command
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (slot_cmd[i] == cmd)
            begin
                age = req.now_time - slot_time[i];
                if (slot_acked[i])
                begin
                    hold = (cmd[6:0] == upgrade_cmd) ? upgrade_hold : other_hold;
                    if (age > hold)
                    begin
                        slot_cmd[i]    = 8'h00;
                        slot_seq[i]    = 8'h00;
                        slot_time[i]   = '0;
                        slot_acked[i]  = 1'b0;
                        res.status     = ST_CLEARED;
                        res.slot_index = i[2:0];
                        return res;
                    end
                    res.status = ST_SUPPRESSED;
                    return res;
                end
                if (age < retry_timeout)
                begin
                    res.status = ST_SUPPRESSED;
                    return res;
                end
            end
        end
        // Allocate the first free slot
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (slot_cmd[i] == 8'h00)
            begin
                slot_cmd[i]       = cmd;
                slot_seq[i]       = seq_counter;
                slot_time[i]      = req.now_time;
                slot_acked[i]     = 1'b0;
                res.status        = ST_SENT;
                res.slot_index    = i[2:0];
                res.sent_sequence = seq_counter;
                if (seq_counter == SEQ_WRAP)
                begin
                    seq_counter = SEQ_FIRST;
                    seq_wrapped = 1'b1;
                end
                else
                begin
                    seq_counter = seq_counter + 8'd1;
                end
                return res;
            end
        end
        res.status = ST_NO_SLOT;
        return res;
    endfunction

    // Pick a request beat, mostly aimed at live entries and timeout edges
    function automatic in_t random_request();
        in_t         req;
        int          pick;
        int          s;
        logic [31:0] hold;
        logic [6:0]  cmd7;
        req.action       = ACT_SEND;
        req.ack_sequence = 8'($urandom);
        clock_now        = ($urandom_range(19) == 0) ? $urandom
                                                     : clock_now + $urandom_range(40);
        req.now_time     = clock_now;
        req.command_code = 8'h01;
        pick             = $urandom_range(99);
        s                = $urandom_range(QUEUE_DEPTH - 1);
        if (pick < 30 && slot_cmd[s] != 8'h00)
        begin
            // acknowledge a live entry
            req.action       = ACT_ACK;
            req.command_code = slot_cmd[s] | 8'h80;
            req.ack_sequence = slot_seq[s];
        end
        else if (pick < 60 && slot_cmd[s] != 8'h00)
        begin
            // resend a live command near one of its limits
            hold = (slot_cmd[s][6:0] == upgrade_cmd) ? upgrade_hold : other_hold;
            req.command_code    = slot_cmd[s];
            req.command_code[7] = 1'($urandom_range(1));
            case ($urandom_range(5))
                0:       req.now_time = slot_time[s] + retry_timeout - 32'd1;
                1:       req.now_time = slot_time[s] + retry_timeout;
                2:       req.now_time = slot_time[s] + hold;
                3:       req.now_time = slot_time[s] + hold + 32'd1;
                4:       req.now_time = slot_time[s] + $urandom_range(500);
                default: req.now_time = $urandom;
            endcase
        end
        else if (pick < 85)
        begin
            // fresh send, mostly from a handful of codes
            case ($urandom_range(3))
                0:       cmd7 = upgrade_cmd;
                1:       cmd7 = 7'($urandom_range(6, 1));
                default: cmd7 = 7'($urandom_range(127, 1));
            endcase
            req.command_code    = {1'b0, cmd7};
            req.command_code[7] = ($urandom_range(7) == 0);
        end
        else
        begin
            // noise over the whole field range
            req.action       = 1'($urandom_range(1));
            req.command_code = 8'($urandom_range(255, 1));
        end
        return req;
    endfunction

    function automatic void add_row(input logic act, input logic [7:0] code,
                                    input logic [7:0] aseq, input logic [31:0] t,
                                    input bit typed, input logic [2:0] st,
                                    input logic [2:0] slot, input logic [7:0] sseq);
        dir_row_t row;
        row.req.action             = act;
        row.req.command_code       = code;
        row.req.ack_sequence       = aseq;
        row.req.now_time           = t;
        row.typed                  = typed;
        row.want.status            = st;
        row.want.slot_index        = slot;
        row.want.sent_sequence     = sseq;
        dir_rows.push_back(row);
    endfunction

    // Drive one request beat, with optional idle cycles ahead of it
    task automatic push_request(input in_t req, input bit typed, input out_t typed_result);
        out_t predicted;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        predicted = track_request(req);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RETRY_TIMEOUT: retry_timeout = value;
            CFG_UPGRADE_HOLD:  upgrade_hold  = value;
            CFG_OTHER_HOLD:    other_hold    = value;
            CFG_UPGRADE_CODE:  upgrade_cmd   = value[6:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding result drain
    task automatic settle_block();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (QUEUE_DEPTH + 4) @(negedge clk);
    endtask

    task automatic load_settings(input logic [31:0] rt, input logic [31:0] uh,
                                 input logic [31:0] oh, input logic [6:0] uc);
        settle_block();
        write_reg(CFG_RETRY_TIMEOUT, rt);
        write_reg(CFG_UPGRADE_HOLD, uh);
        write_reg(CFG_OTHER_HOLD, oh);
        write_reg(CFG_UPGRADE_CODE, {25'd0, uc});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit until_wrap);
        int n;
        n = 0;
        while (n < count || (until_wrap && !seq_wrapped && n < WRAP_CAP))
        begin
            push_request(random_request(), 1'b0, '0);
            n++;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing pending: status %0d slot %0d seq %02h",
                         $time, out_data.status, out_data.slot_index, out_data.sent_sequence);
            end
            else
            begin
                expected_res = pending_results.pop_front();
                if (out_data.status != expected_res.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, expected_res.status, out_data.status);
                end
                if (out_data.slot_index != expected_res.slot_index)
                begin
                    mismatches++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, expected_res.slot_index, out_data.slot_index);
                end
                if (out_data.sent_sequence != expected_res.sent_sequence)
                begin
                    mismatches++;
                    $display("%0t: sent_sequence expected %02h actual %02h",
                             $time, expected_res.sent_sequence, out_data.sent_sequence);
                end
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_cmd[i]   = 8'h00;
            slot_seq[i]   = 8'h00;
            slot_time[i]  = '0;
            slot_acked[i] = 1'b0;
        end
        seq_counter   = SEQ_FIRST;
        seq_wrapped   = 1'b0;
        retry_timeout = RETRY_TIMEOUT_RST;
        upgrade_hold  = UPGRADE_HOLD_RST;
        other_hold    = OTHER_HOLD_RST;
        upgrade_cmd   = UPGRADE_CODE_RST;
        clock_now     = 32'd5000;

        // Directed rows, run under the reset settings
        // empty table: free slots must not match an ack
        add_row(ACT_ACK,  8'h80, 8'h00, 32'd0,        1, ST_ACK_MISS,   3'd0, 8'h00);
        add_row(ACT_ACK,  8'hFF, 8'hFF, 32'hFFFFFFFF, 1, ST_ACK_MISS,   3'd0, 8'h00);
        // code zero in the low seven bits records nothing
        add_row(ACT_SEND, 8'h00, 8'h00, 32'd0,        1, ST_SUPPRESSED, 3'd0, 8'h00);
        add_row(ACT_SEND, 8'h80, 8'hFF, 32'd0,        1, ST_SUPPRESSED, 3'd0, 8'h00);
        // first send, retry window and its edge
        add_row(ACT_SEND, 8'h05, 8'h00, 32'd1000,     1, ST_SENT,       3'd0, 8'h80);
        add_row(ACT_SEND, 8'h05, 8'h00, 32'd1059,     1, ST_SUPPRESSED, 3'd0, 8'h00);
        add_row(ACT_SEND, 8'h05, 8'h00, 32'd1060,     1, ST_SENT,       3'd1, 8'h81);
        // ack, repeated ack, ack without bit 7
        add_row(ACT_ACK,  8'h85, 8'h81, 32'd0,        1, ST_ACK_MATCH,  3'd1, 8'h00);
        add_row(ACT_ACK,  8'h85, 8'h81, 32'd0,        1, ST_ACK_MATCH,  3'd1, 8'h00);
        add_row(ACT_ACK,  8'h05, 8'h80, 32'd0,        1, ST_ACK_MISS,   3'd0, 8'h00);
        // confirmed entry: hold edge, then cleared past it
        add_row(ACT_SEND, 8'h05, 8'h00, 32'd1360,     1, ST_SUPPRESSED, 3'd0, 8'h00);
        add_row(ACT_SEND, 8'h85, 8'h00, 32'd1361,     1, ST_CLEARED,    3'd1, 8'h00);
        // upgrade code uses the long hold
        add_row(ACT_SEND, 8'h55, 8'h00, 32'd0,        1, ST_SENT,       3'd1, 8'h82);
        add_row(ACT_ACK,  8'hD5, 8'h82, 32'd0,        1, ST_ACK_MATCH,  3'd1, 8'h00);
        add_row(ACT_SEND, 8'h55, 8'h00, 32'd21600,    1, ST_SUPPRESSED, 3'd0, 8'h00);
        add_row(ACT_SEND, 8'hD5, 8'h00, 32'd21601,    1, ST_CLEARED,    3'd1, 8'h00);
        // age wraps through zero
        add_row(ACT_SEND, 8'h7F, 8'h00, 32'hFFFFFFF0, 1, ST_SENT,       3'd1, 8'h83);
        add_row(ACT_SEND, 8'h7F, 8'h00, 32'h00000010, 1, ST_SUPPRESSED, 3'd0, 8'h00);
        // fill the table, then overflow it
        add_row(ACT_SEND, 8'h01, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h02, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h03, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h04, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h06, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h07, 8'h00, 32'h100,      0, ST_SENT,       3'd0, 8'h00);
        add_row(ACT_SEND, 8'h08, 8'h00, 32'h100,      1, ST_NO_SLOT,    3'd0, 8'h00);
        add_row(ACT_ACK,  8'hFF, 8'h83, 32'd0,        1, ST_ACK_MATCH,  3'd1, 8'h00);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < dir_rows.size(); i++)
            push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // Low extremes, sender idling
        send_idle_pct  = 73;
        recv_stall_pct = 0;
        load_settings(32'd0, 32'd0, 32'd0, 7'd1);
        run_random(80, 1'b0);

        // High extremes, receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        load_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd127);
        run_random(60, 1'b0);

        // Random settings, both sides idling a little
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        load_settings($urandom_range(120), $urandom_range(400), $urandom_range(400),
                      7'($urandom_range(127, 1)));
        run_random(90, 1'b0);

        // Reset values again, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_settings(RETRY_TIMEOUT_RST, UPGRADE_HOLD_RST, OTHER_HOLD_RST, UPGRADE_CODE_RST);
        run_random(80, 1'b0);

        // Short limits; keep going a while longer if the sequence has not wrapped
        send_idle_pct  = 10;
        recv_stall_pct = 73;
        load_settings(32'd3, 32'd2, 32'd1, 7'($urandom_range(6, 1)));
        run_random(90, 1'b1);

        settle_block();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/pct_pkg.sv
rtl/core/pct_ctrl.sv
rtl/core/pct_dp.sv
rtl/core/pending_command_tracker_unit.sv
test/pending_command_tracker_unit_test.sv
